### rtl/core/fdsf_pkg.sv
// ----------------------------------------------------------------------------
// fdsf_pkg
// Shared types and constants for the frame difference span finder.
// ----------------------------------------------------------------------------
package fdsf_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned LANE_IW    = 2;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned START_W    = 10;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned LEN_W      = 11;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 11'd320;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 11'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH = 1'b0,
    REG_ROW_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [WORD_W-1:0] current_word;
    logic [WORD_W-1:0] previous_word;
  } fdsf_in_t;

  typedef struct packed {
    logic               span_valid;
    logic [START_W-1:0] span_start;
    logic [ROW_W-1:0]   span_row;
    logic [LEN_W-1:0]   span_length;
    logic               frame_done;
  } fdsf_out_t;

  typedef struct packed {
    logic               found;
    logic [LANE_IW-1:0] lo;
    logic [LANE_IW-1:0] hi;
  } fdsf_hits_t;

endpackage

### rtl/core/fdsf_stream_if.sv
// ----------------------------------------------------------------------------
// fdsf_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface fdsf_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

### rtl/core/fdsf_lane.sv
// ----------------------------------------------------------------------------
// fdsf_lane
// One byte lane: flags a changed pixel that lies inside the row width.
// ----------------------------------------------------------------------------
module fdsf_lane
  import fdsf_pkg::*;
#(
  parameter int unsigned CW = 10,
  parameter int unsigned WW = 11
) (
  input  logic [PIX_W-1:0] cur_i,
  input  logic [PIX_W-1:0] prev_i,
  input  logic [CW-1:0]    column_i,
  input  logic [WW-1:0]    width_i,
  output logic             hit_o
);

  logic [31:0] column_ext;
  logic [31:0] width_ext;

  assign column_ext = 32'(column_i);
  assign width_ext  = 32'(width_i);
  assign hit_o      = (cur_i != prev_i) && (column_ext < width_ext);

endmodule

### rtl/core/fdsf_merge.sv
// ----------------------------------------------------------------------------
// fdsf_merge
// Combines the lane flags into first and last changed byte of the word.
// ----------------------------------------------------------------------------
module fdsf_merge
  import fdsf_pkg::*;
(
  input  logic [LANES-1:0] hits_i,
  output fdsf_hits_t       merged_o
);

  always_comb begin
    merged_o = '0;
    for (int unsigned b = 0; b < LANES; b++) begin
      if (hits_i[b]) begin
        if (!merged_o.found) begin
          merged_o.lo = LANE_IW'(b);
        end
        merged_o.hi    = LANE_IW'(b);
        merged_o.found = 1'b1;
      end
    end
  end

endmodule

### rtl/core/frame_diff_span_finder.sv
// ----------------------------------------------------------------------------
// frame_diff_span_finder
// Finds runs of changed pixels between two frames streamed word by word.
//
// in_i carries one word of four pixel bytes from the new and the shown frame
// per transfer, in raster order, lowest byte leftmost. out_o carries a result
// when a span of changed bytes closes (an unchanged word follows or the row
// ends) and on the last word of the frame, which sets frame_done.
// row_width and row_count are written through cfg_we_i / cfg_idx_i /
// cfg_data_i only while the block is idle: a rule for the user, not enforced.
// Four byte lanes compare the word in parallel and a merge stage picks the
// first and last changed byte; the run tracker updates in the same cycle.
// The result of an input transfer is in the output register in the next cycle.
// Throughput is one word per cycle: a new word is taken whenever the output
// register is empty or being drained in the same cycle.
// When the receiver stalls the result is held and the input stalls until
// that result is taken, whether or not the next word would give a result.
// Reset sets row_width to 320, row_count to 240 and the position to the
// start of a frame; no result is pending.
// ----------------------------------------------------------------------------
module frame_diff_span_finder
  import fdsf_pkg::*;
#(
  parameter int unsigned MAX_ROW_PIXELS = 1024,
  parameter int unsigned MAX_ROWS       = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  fdsf_stream_if.sink          in_i,
  fdsf_stream_if.source        out_o
);

  localparam int unsigned WCW = (MAX_ROW_PIXELS > 4) ? $clog2(MAX_ROW_PIXELS / 4) : 1;
  localparam int unsigned BCW = WCW + LANE_IW;
  localparam int unsigned WW  = $clog2(MAX_ROW_PIXELS + 1);
  localparam int unsigned RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned HW  = $clog2(MAX_ROWS + 1);

  logic [CFG_W-1:0] row_width_q, row_count_q;
  logic [WCW-1:0]   word_column_q, word_column_d;
  logic [RIW-1:0]   row_index_q, row_index_d;
  logic             in_run_q, in_run_d;
  logic [BCW-1:0]   run_first_q, run_first_d;
  logic [BCW-1:0]   run_last_q, run_last_d;
  logic             out_valid_q, out_valid_d;
  fdsf_out_t        out_data_q, out_data_d;

  logic [WW-1:0]    width_c;
  logic [HW-1:0]    rows_c;
  logic [31:0]      words_c;
  logic             row_end, frame_end, emit, in_xfer;
  logic [LANES-1:0] hits;
  fdsf_hits_t       merged;
  fdsf_in_t         in_data;
  logic [BCW-1:0]   first_now, last_now;
  logic [31:0]      first_ext, last_ext, len_ext, row_ext;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RST;
      row_count_q <= ROW_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ROW_WIDTH: row_width_q <= cfg_data_i;
        REG_ROW_COUNT: row_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_width_q == '0) begin
      width_c = WW'(1);
    end else if (32'(row_width_q) > MAX_ROW_PIXELS) begin
      width_c = WW'(MAX_ROW_PIXELS);
    end else begin
      width_c = WW'(row_width_q);
    end
    if (row_count_q == '0) begin
      rows_c = HW'(1);
    end else if (32'(row_count_q) > MAX_ROWS) begin
      rows_c = HW'(MAX_ROWS);
    end else begin
      rows_c = HW'(row_count_q);
    end
  end

  assign words_c   = (32'(width_c) + 32'd3) >> 2;
  assign row_end   = (32'(word_column_q) + 32'd1) >= words_c;
  assign frame_end = row_end && ((32'(row_index_q) + 32'd1) >= 32'(rows_c));

  // byte lanes
  assign in_data = in_i.payload;

  for (genvar b = 0; b < LANES; b++) begin : g_lane
    fdsf_lane #(
      .CW (BCW),
      .WW (WW)
    ) u_lane (
      .cur_i    (in_data.current_word[b*PIX_W +: PIX_W]),
      .prev_i   (in_data.previous_word[b*PIX_W +: PIX_W]),
      .column_i ({word_column_q, LANE_IW'(b)}),
      .width_i  (width_c),
      .hit_o    (hits[b])
    );
  end

  fdsf_merge u_merge (
    .hits_i   (hits),
    .merged_o (merged)
  );

  // run tracking
  assign first_now = in_run_q ? run_first_q : {word_column_q, merged.lo};
  assign last_now  = merged.found ? {word_column_q, merged.hi} : run_last_q;
  assign emit      = merged.found ? row_end : in_run_q;

  assign first_ext = 32'(first_now);
  assign last_ext  = 32'(last_now);
  assign len_ext   = last_ext - first_ext + 32'd1;
  assign row_ext   = 32'(row_index_q);

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_comb begin
    word_column_d = word_column_q;
    row_index_d   = row_index_q;
    in_run_d      = in_run_q;
    run_first_d   = run_first_q;
    run_last_d    = run_last_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_data_d    = out_data_q;
    if (in_xfer) begin
      if (merged.found) begin
        in_run_d    = 1'b1;
        run_first_d = first_now;
        run_last_d  = last_now;
      end
      if (emit || row_end) begin
        in_run_d = 1'b0;
      end
      if (row_end) begin
        word_column_d = '0;
        row_index_d   = frame_end ? '0 : row_index_q + RIW'(1);
      end else begin
        word_column_d = word_column_q + WCW'(1);
      end
      out_valid_d            = emit || frame_end;
      out_data_d.span_valid  = emit;
      out_data_d.span_start  = emit ? first_ext[START_W-1:0] : '0;
      out_data_d.span_row    = emit ? row_ext[ROW_W-1:0] : '0;
      out_data_d.span_length = emit ? len_ext[LEN_W-1:0] : '0;
      out_data_d.frame_done  = frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_column_q <= '0;
      row_index_q   <= '0;
      in_run_q      <= 1'b0;
      run_first_q   <= '0;
      run_last_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      word_column_q <= word_column_d;
      row_index_q   <= row_index_d;
      in_run_q      <= in_run_d;
      run_first_q   <= run_first_d;
      run_last_q    <= run_last_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  // checks
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && frame_end |=> (row_index_q == '0) && (word_column_q == '0))
    else $error("position not cleared after frame end");

  a_row_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && row_end |=> !in_run_q)
    else $error("run left open across a row boundary");

  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_run_q |-> (run_last_q >= run_first_q))
    else $error("open run ends before it starts");

  a_result_on_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && frame_end |=> out_valid_q && out_data_q.frame_done)
    else $error("frame end transfer gave no result");

endmodule

### verif/fdsf_span_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsf_span_checker
// Watches the configuration port and both channels of the span finder. Each
// word taken on the input runs through a raster predictor that tracks its own
// copy of row_width, row_count and the run state; the spans it produces are
// queued and each result leaving the block is compared field by field with
// the oldest one. Failures and results still owed go back to the top.
// ----------------------------------------------------------------------------
module fdsf_span_checker
  import fdsf_pkg::*;
#(
  parameter int unsigned MAX_ROW_PIXELS = 1024,
  parameter int unsigned MAX_ROWS       = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  fdsf_in_t             in_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  fdsf_out_t            out_span_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          spans_o,
  output int unsigned          frames_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] count_reg;
  int unsigned      col_pos;
  int unsigned      row_pos;
  bit               run_open;
  int unsigned      run_first;
  int unsigned      run_last;
  fdsf_out_t        span_q[$];
  int unsigned      reports;

  task automatic advance_raster(input fdsf_in_t word, output bit produced,
                                output fdsf_out_t res);
    int unsigned       w;
    int unsigned       h;
    int unsigned       words;
    int unsigned       base;
    int unsigned       first;
    int unsigned       last;
    int unsigned       emit_row;
    logic [WORD_W-1:0] x;
    bit                row_end;
    bit                frame_end;
    bit                emit;
    int                lo;
    int                hi;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : width_reg);
    h = (count_reg == 0) ? 1 : ((count_reg > MAX_ROWS) ? MAX_ROWS : count_reg);
    words = (w + 3) >> 2;
    x = word.current_word ^ word.previous_word;
    base = col_pos * LANES;
    row_end = (col_pos + 1) >= words;
    frame_end = row_end && ((row_pos + 1) >= h);
    emit = 1'b0;
    first = 0;
    last = 0;
    emit_row = row_pos;
    lo = -1;
    hi = -1;
    // bytes past the row width never count as changed
    for (int b = 0; b < LANES; b++) begin
      if ((base + b) < w && x[PIX_W*b +: PIX_W] != '0) begin
        if (lo < 0) lo = b;
        hi = b;
      end
    end
    if (lo >= 0) begin
      if (!run_open) begin
        run_open = 1'b1;
        run_first = base + int'(lo);
      end
      run_last = base + int'(hi);
      if (row_end) emit = 1'b1;
    end else if (run_open) begin
      emit = 1'b1;
    end
    if (emit) begin
      first = run_first;
      last = run_last;
      run_open = 1'b0;
    end
    if (row_end) begin
      run_open = 1'b0;
      col_pos = 0;
      row_pos = frame_end ? 0 : ((row_pos + 1) & 32'hFFF);
    end else begin
      col_pos = (col_pos + 1) & 32'h3FF;
    end
    produced = emit || frame_end;
    res.span_valid  = emit;
    res.span_start  = emit ? START_W'(first) : '0;
    res.span_row    = emit ? ROW_W'(emit_row) : '0;
    res.span_length = emit ? LEN_W'(last - first + 1) : '0;
    res.frame_done  = frame_end;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fdsf_out_t want;
    fdsf_out_t got;
    bit        produced;
    if (!rst_ni) begin
      width_reg = ROW_WIDTH_RST;
      count_reg = ROW_COUNT_RST;
      col_pos = 0;
      row_pos = 0;
      run_open = 1'b0;
      run_first = 0;
      run_last = 0;
      span_q.delete();
      reports = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      spans_o <= 0;
      frames_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_span_i;
        if (span_q.size() == 0) begin
          if (reports < REPORT_LIMIT)
            $display("%0t: result with nothing outstanding: valid %0d start %0d row %0d len %0d done %0d",
                     $realtime, got.span_valid, got.span_start, got.span_row,
                     got.span_length, got.frame_done);
          reports++;
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = span_q.pop_front();
          if (got.span_valid !== want.span_valid || got.span_start !== want.span_start ||
              got.span_row !== want.span_row || got.span_length !== want.span_length ||
              got.frame_done !== want.frame_done) begin
            if (reports < REPORT_LIMIT) begin
              $display("%0t: span mismatch", $realtime);
              $display("  expected valid %0d start %0d row %0d len %0d done %0d",
                       want.span_valid, want.span_start, want.span_row,
                       want.span_length, want.frame_done);
              $display("  actual   valid %0d start %0d row %0d len %0d done %0d",
                       got.span_valid, got.span_start, got.span_row,
                       got.span_length, got.frame_done);
            end
            reports++;
            fail_count_o <= fail_count_o + 1;
          end
          if (want.span_valid) spans_o <= spans_o + 1;
          if (want.frame_done) frames_o <= frames_o + 1;
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_raster(in_word_i, produced, want);
        if (produced) span_q.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_ROW_WIDTH: width_reg = cfg_data_i;
          REG_ROW_COUNT: count_reg = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= span_q.size();
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives word pairs into the span finder through a sequence of row geometries,
// from tiny rows to the widest row and out-of-range register values, with
// random sender gaps and receiver stalls. A separate checker predicts every
// span and frame end; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import fdsf_pkg::*;

  localparam int unsigned MAX_ROW_PIXELS = 1024;
  localparam int unsigned MAX_ROWS       = 1024;
  localparam int unsigned RANDOM_ITEMS   = 280;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned CYCLE_LIMIT    = 200000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned spans_seen;
  int unsigned frames_seen;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned settings_used = 0;
  int unsigned send_idle_pct = 6;
  int unsigned recv_stall_pct = 77;

  fdsf_stream_if #(.payload_t(fdsf_in_t))  in_ch ();
  fdsf_stream_if #(.payload_t(fdsf_out_t)) out_ch ();

  frame_diff_span_finder #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .MAX_ROWS      (MAX_ROWS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  fdsf_span_checker #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .MAX_ROWS      (MAX_ROWS)
  ) span_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_word_i   (in_ch.payload),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_span_i  (out_ch.payload),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .spans_o     (spans_seen),
    .frames_o    (frames_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic fdsf_in_t random_pair(input int unsigned p_diff);
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] mask;
    cur = $urandom;
    mask = '0;
    if ($urandom_range(0, 99) < p_diff) begin
      case ($urandom_range(0, 3))
        0: mask = '1;
        1: mask = 32'hFF << (PIX_W * $urandom_range(0, 3));
        2: begin
          for (int b = 0; b < LANES; b++)
            if ($urandom_range(0, 1)) mask[PIX_W*b +: PIX_W] = $urandom_range(1, 255);
        end
        default: mask = $urandom;
      endcase
    end
    return '{current_word: cur, previous_word: cur ^ mask};
  endfunction

  task automatic push_word(input logic [WORD_W-1:0] cur, input logic [WORD_W-1:0] prev);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{current_word: cur, previous_word: prev};
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic push_random(input int unsigned n, input int unsigned p_diff);
    fdsf_in_t pair;
    repeat (n) begin
      pair = random_pair(p_diff);
      push_word(pair.current_word, pair.previous_word);
    end
  endtask

  // hold the input back until every outstanding result has come out
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] r);
    settle();
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= REG_ROW_WIDTH;
    cfg_data <= w;
    @(negedge clk_i);
    cfg_idx <= REG_ROW_COUNT;
    cfg_data <= r;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] r;
    int unsigned      n;
    int unsigned      random_sent;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_ROW_WIDTH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: run over two words, closed by an equal word
    push_word(32'h0000_0000, 32'h0000_0000);
    push_word(32'hFFFF_FFFF, 32'h0000_0000);
    push_word(32'h0000_FF00, 32'h0000_0000);
    push_word(32'h5A5A_5A5A, 32'h5A5A_5A5A);
    push_word(32'hFF00_0000, 32'h0000_0000);
    // narrow the row while a run is open and the column is past the row end
    set_geometry(11'd5, 11'd2);
    push_word(32'hFFFF_FFFF, 32'h0000_0000);
    push_word(32'h0000_0000, 32'h0000_0000);
    push_word(32'hFFFF_FF00, 32'h0000_0000);
    push_word(32'h0000_00FF, 32'h0000_0000);
    push_word(32'hFFFF_FFFF, 32'h0000_0000);
    push_word(32'h0000_0000, 32'hFFFF_FFFF);
    push_word(32'hA5A5_A5A5, 32'hA5A5_A5A5);
    // zero registers act as one pixel and one row
    set_geometry(11'd0, 11'd0);
    push_word(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    push_word(32'hFFFF_FF00, 32'h0000_0000);
    push_word(32'h8000_0000, 32'h0000_0000);
    push_word(32'hFFFF_FFFF, 32'h0000_0000);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (random_sent >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 77;
        recv_stall_pct = 6;
      end
      case ($urandom_range(0, 9))
        0: w = 11'd0;
        1: w = 11'd1;
        2: w = 11'd1024;
        3: w = 11'd2047;
        4: w = $urandom_range(1025, 2046);
        default: w = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 7))
        0: r = 11'd0;
        1: r = 11'd1;
        2: r = 11'd2047;
        3: r = 11'd1024;
        default: r = $urandom_range(2, 6);
      endcase
      n = $urandom_range(10, 90);
      set_geometry(w, r);
      case ($urandom_range(0, 2))
        0: push_random(n, 15);
        1: push_random(n, 50);
        default: push_random(n, 90);
      endcase
      random_sent += n;
    end

    // widest row: last pixel alone, then a full-width span
    set_geometry(11'd1, 11'd1);
    push_word(32'h0000_0000, 32'h0000_0000);
    set_geometry(11'd2047, 11'd1);
    push_random(254, 50);
    push_word(32'h1234_5678, 32'h1234_5678);
    push_word(32'hFF00_0000, 32'h0000_0000);
    repeat (256) push_word(32'hFFFF_FFFF, 32'h0000_0000);

    settle();
    $display("covered %0d words over %0d register settings,", words_sent, settings_used);
    $display("%0d changed spans and %0d frame ends checked", spans_seen, frames_seen);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
